>>> src/sine_cosine_lut_interp_defines.svh
// Assertion macros used by the checker file.
`ifndef SINE_COSINE_LUT_INTERP_DEFINES_SVH
`define SINE_COSINE_LUT_INTERP_DEFINES_SVH

// Implication checked in the same cycle, off while reset is asserted.
`define SCL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, off while reset is asserted.
`define SCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, active through reset.
`define SCL_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/scl_pkg.sv
`timescale 1ns / 1ps

package scl_pkg;

    // Result and table widths
    localparam int VALUE_W = 16;
    localparam int ROM_W   = 17;
    localparam logic [VALUE_W-1:0] MAG_MAX = 16'h7FFF;

    // pi in Q30 and 1.0 in Q30, used to build the quarter-wave table
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Per-stage load enables of the lane pipeline
    typedef struct packed {
        logic lookup;
        logic mult;
        logic result;
    } t_stage_en;

    // sin(x) in Q30 for 0 <= x <= pi/2, ten-term Taylor series
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd342;
        sum  = sum - $signed(term);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if ($unsigned(sum) > Q30_ONE) begin
            sum = $signed(Q30_ONE);
        end
        return $unsigned(sum);
    endfunction

endpackage

>>> src/scl_rom.sv
`timescale 1ns / 1ps

module scl_rom #(
    parameter int TABLE_INTERVALS = 128,
    parameter int IDX_W           = $clog2(TABLE_INTERVALS + 1)
) (
    input  logic [IDX_W-1:0]            i_idx_a,
    input  logic [IDX_W-1:0]            i_idx_b,
    output logic [scl_pkg::ROM_W-1:0]   o_a,
    output logic [scl_pkg::ROM_W-1:0]   o_b
);
    import scl_pkg::*;

    localparam logic [63:0] ROM_DIV = 64'(2 * TABLE_INTERVALS);

    typedef logic [ROM_W-1:0] t_rom [0:TABLE_INTERVALS];

    // Entry k = round(32768 * sin(k*pi / (2*intervals))), built at elaboration
    function automatic t_rom build_rom();
        t_rom        r;
        logic [63:0] x;
        logic [63:0] s;
        for (int k = 0; k <= TABLE_INTERVALS; k++) begin
            x    = (64'(k) * PI_Q30) / ROM_DIV;
            s    = sine_q30(x);
            r[k] = ROM_W'((s + 64'd16384) >> 15);
        end
        return r;
    endfunction

    localparam t_rom ROM = build_rom();

    // Two read ports: entry and its upper neighbor
    assign o_a = ROM[i_idx_a];
    assign o_b = ROM[i_idx_b];

endmodule

>>> src/scl_lane.sv
`timescale 1ns / 1ps

module scl_lane #(
    parameter int TABLE_INTERVALS = 128,
    parameter int PHASE_WIDTH     = 16
) (
    input  logic                              i_clk,
    input  scl_pkg::t_stage_en                i_en,
    input  logic [PHASE_WIDTH-1:0]            i_phase,
    output logic signed [scl_pkg::VALUE_W-1:0] o_value
);
    import scl_pkg::*;

    localparam int QW    = PHASE_WIDTH - 2;
    localparam int IDX_W = $clog2(TABLE_INTERVALS + 1);
    localparam int T_W   = QW + IDX_W;
    localparam int D_W   = ROM_W + 1;
    localparam int S_W   = D_W + QW + 1;
    localparam logic [PHASE_WIDTH-2:0] QUARTER   = (PHASE_WIDTH-1)'(1) << QW;
    localparam logic [PHASE_WIDTH-1:0] HALF      = PHASE_WIDTH'(1) << (PHASE_WIDTH - 1);
    localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(TABLE_INTERVALS);
    localparam logic [T_W-1:0]         INTERVALS = T_W'(TABLE_INTERVALS);
    localparam logic [S_W-1:0]         ROUND_Q   = S_W'(1) << (QW - 1);

    // Fold the phase into one quarter
    logic [PHASE_WIDTH-2:0] h;
    logic [PHASE_WIDTH-2:0] m;
    logic [PHASE_WIDTH-1:0] mirror;
    logic [T_W-1:0]         t;
    logic [IDX_W-1:0]       idx;
    logic [IDX_W-1:0]       nxt;
    logic [ROM_W-1:0]       rom_a;
    logic [ROM_W-1:0]       rom_b;

    always_comb begin
        h      = i_phase[PHASE_WIDTH-2:0];
        mirror = HALF - {1'b0, h};
        m      = (h > QUARTER) ? mirror[PHASE_WIDTH-2:0] : h;
        t      = T_W'(m) * INTERVALS;
        idx    = t[T_W-1:QW];
        // exact quarter turn: neighbor clamped to last entry
        nxt    = (idx >= LAST_IDX) ? LAST_IDX : idx + IDX_W'(1);
    end

    scl_rom #(
        .TABLE_INTERVALS(TABLE_INTERVALS),
        .IDX_W          (IDX_W)
    ) u_rom (
        .i_idx_a(idx),
        .i_idx_b(nxt),
        .o_a    (rom_a),
        .o_b    (rom_b)
    );

    // Lookup stage: base entry, slope to neighbor, fraction, sign
    logic [ROM_W-1:0]        r_a;
    logic signed [D_W-1:0]   r_d;
    logic [QW-1:0]           r_f;
    logic                    r_neg;

    always_ff @(posedge i_clk) begin
        if (i_en.lookup) begin
            r_a   <= rom_a;
            r_d   <= $signed({1'b0, rom_b}) - $signed({1'b0, rom_a});
            r_f   <= t[QW-1:0];
            r_neg <= i_phase[PHASE_WIDTH-1];
        end
    end

    // Multiply stage: slope times fraction
    logic [ROM_W-1:0]        r_a_mu;
    logic signed [S_W-1:0]   r_prod;
    logic                    r_neg_mu;

    always_ff @(posedge i_clk) begin
        if (i_en.mult) begin
            r_a_mu   <= r_a;
            r_prod   <= r_d * $signed({1'b0, r_f});
            r_neg_mu <= r_neg;
        end
    end

    // Result stage: round, saturate at full scale, apply sign
    logic signed [S_W-1:0]   sum;
    logic [S_W-QW-2:0]       mag;
    logic [VALUE_W-1:0]      sat;
    logic [VALUE_W-1:0]      n_value;
    logic signed [VALUE_W-1:0] r_value;

    always_comb begin
        sum     = $signed({2'b00, r_a_mu, {QW{1'b0}}}) + r_prod + $signed(ROUND_Q);
        mag     = sum[S_W-2:QW];
        sat     = (mag > (S_W-QW-1)'(MAG_MAX)) ? MAG_MAX : mag[VALUE_W-1:0];
        n_value = r_neg_mu ? (~sat + VALUE_W'(1)) : sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.result) begin
            r_value <= $signed(n_value);
        end
    end

    assign o_value = r_value;

endmodule

>>> src/sine_cosine_lut_interp.sv
`timescale 1ns / 1ps
// Pipeline: an accepted item moves through the input, lookup, multiply and result registers,
// in that order, with one lane per output channel.
// Throughput: one item per cycle; each stage holds only while the stage after it stalls.
// Reset: synchronous active-low i_rst_n clears all valid flags; payload is not reset.
// The sine table is a constant built at elaboration, so no clearing pass is needed.

module sine_cosine_lut_interp #(
    parameter int TABLE_INTERVALS = 128,
    parameter int PHASE_WIDTH     = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: phase [PHASE_WIDTH-1:0], zero padded to whole bytes
    input  logic [((PHASE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: cos_value [15:0], sin_value [31:16]
    output logic [2*scl_pkg::VALUE_W-1:0]   o_m_axis_tdata
);
    import scl_pkg::*;

    localparam logic [PHASE_WIDTH-1:0] QUARTER_TURN = PHASE_WIDTH'(1) << (PHASE_WIDTH - 2);

    logic                   r_in_vld;
    logic                   r_vld_lk;
    logic                   r_vld_mu;
    logic                   r_vld_out;
    logic [PHASE_WIDTH-1:0] r_phase;
    logic                   en_in;
    t_stage_en              en;
    logic [PHASE_WIDTH-1:0] cos_phase;
    logic signed [VALUE_W-1:0] cos_value;
    logic signed [VALUE_W-1:0] sin_value;

    // Stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        en.result = !r_vld_out || i_m_axis_tready;
        en.mult   = !r_vld_mu  || en.result;
        en.lookup = !r_vld_lk  || en.mult;
        en_in     = !r_in_vld  || en.lookup;
    end

    assign o_s_axis_tready = en_in;

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_vld_lk  <= 1'b0;
            r_vld_mu  <= 1'b0;
            r_vld_out <= 1'b0;
        end else begin
            if (en_in) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (en.lookup) begin
                r_vld_lk <= r_in_vld;
            end
            if (en.mult) begin
                r_vld_mu <= r_vld_lk;
            end
            if (en.result) begin
                r_vld_out <= r_vld_mu;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_phase <= i_s_axis_tdata[PHASE_WIDTH-1:0];
        end
    end

    // Cosine is the sine a quarter turn ahead
    assign cos_phase = r_phase + QUARTER_TURN;

    scl_lane #(
        .TABLE_INTERVALS(TABLE_INTERVALS),
        .PHASE_WIDTH    (PHASE_WIDTH)
    ) u_cos_lane (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_phase(cos_phase),
        .o_value(cos_value)
    );

    scl_lane #(
        .TABLE_INTERVALS(TABLE_INTERVALS),
        .PHASE_WIDTH    (PHASE_WIDTH)
    ) u_sin_lane (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_phase(r_phase),
        .o_value(sin_value)
    );

    assign o_m_axis_tvalid = r_vld_out;
    assign o_m_axis_tdata  = {sin_value, cos_value};

endmodule

>>> src/scl_checker.sv
`timescale 1ns / 1ps
`include "sine_cosine_lut_interp_defines.svh"

module scl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata
);

    // Stalled result holds its value
    `SCL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // Results never reach the negative full-scale code
    `SCL_ASSERT_SAME(a_out_sat, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tdata[15:0] != 16'h8000) && (o_m_axis_tdata[31:16] != 16'h8000), "result not saturated")

    // With no result pending the pipeline always takes an item
    `SCL_ASSERT_SAME(a_in_ready, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready, "not ready with empty output")

    // Reset empties the pipeline
    `SCL_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_m_axis_tvalid, "result valid after reset")

endmodule

bind sine_cosine_lut_interp scl_checker u_scl_checker (.*);
